// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the block loop filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication or plain property, sampled on the rising edge, off in reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen on a rising edge
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- hdl/blf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blf_pkg
// Shared constants and types of the 8x8 block loop filter.
// ----------------------------------------------------------------------------
package blf_pkg;

	localparam int NCOLS     = 8;
	localparam int ROW_BITS  = 3;
	localparam int QDEPTH    = 3;
	localparam int LVL_BITS  = 2;
	localparam int RND_EDGE  = 2;
	localparam int RND_INNER = 8;

	localparam logic [ROW_BITS-1:0] FIRST_ROW = 3'd0;
	localparam logic [ROW_BITS-1:0] LAST_ROW  = 3'd7;

	typedef struct packed {
		logic [ROW_BITS-1:0] row;
		logic                last;
	} row_tag_t;

	// Results written into the output queue in one cycle
	typedef struct packed {
		logic [LVL_BITS-1:0] count;
		row_tag_t            tag0;
		row_tag_t            tag1;
	} push_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/block_loop_filter_8x8.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_loop_filter_8x8
// Separable 1-2-1 loop filter over an 8x8 block, one pixel row per transfer.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, pixel_0..pixel_7      | row in
//  out     | out_valid, out_ready, out_row,            | row out
//          | out_pixel_0..out_pixel_7, run_last        |
//
// One input row is taken per cycle. The horizontal pass and the vertical pass
// are combinational, between the stored filtered rows and a three-entry output
// queue, which registers each result before the out channel shows it.
// The eighth row of a block writes two results; the queue depth lets the
// stream keep one row per cycle when the sink takes one result per cycle.
// Input stalls only while the queue lacks room for the row's results.
// Reset clears the row counter and empties the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module block_loop_filter_8x8 #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIXEL_BITS-1:0] pixel_0,
	input  logic [PIXEL_BITS-1:0] pixel_1,
	input  logic [PIXEL_BITS-1:0] pixel_2,
	input  logic [PIXEL_BITS-1:0] pixel_3,
	input  logic [PIXEL_BITS-1:0] pixel_4,
	input  logic [PIXEL_BITS-1:0] pixel_5,
	input  logic [PIXEL_BITS-1:0] pixel_6,
	input  logic [PIXEL_BITS-1:0] pixel_7,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            out_row,
	output logic [PIXEL_BITS-1:0] out_pixel_0,
	output logic [PIXEL_BITS-1:0] out_pixel_1,
	output logic [PIXEL_BITS-1:0] out_pixel_2,
	output logic [PIXEL_BITS-1:0] out_pixel_3,
	output logic [PIXEL_BITS-1:0] out_pixel_4,
	output logic [PIXEL_BITS-1:0] out_pixel_5,
	output logic [PIXEL_BITS-1:0] out_pixel_6,
	output logic [PIXEL_BITS-1:0] out_pixel_7,
	output logic                  run_last
);
	import blf_pkg::*;

	// horizontal results need two extra bits, the vertical sum four
	localparam int HW = PIXEL_BITS + 2;
	localparam int SW = PIXEL_BITS + 4;

	logic [NCOLS-1:0][PIXEL_BITS-1:0] pix;
	logic [HW-1:0]                    hf      [NCOLS];
	logic [HW-1:0]                    hfilt_older_q [NCOLS];
	logic [HW-1:0]                    hfilt_newer_q [NCOLS];
	logic [ROW_BITS-1:0]              row_count_q;

	logic [NCOLS-1:0][PIXEL_BITS-1:0] edge_newer;
	logic [NCOLS-1:0][PIXEL_BITS-1:0] edge_cur;
	logic [NCOLS-1:0][PIXEL_BITS-1:0] inner_row;
	logic [NCOLS-1:0][PIXEL_BITS-1:0] push_pix0;
	logic [NCOLS-1:0][PIXEL_BITS-1:0] head_pix;

	logic [LVL_BITS-1:0]              need;
	logic [LVL_BITS-1:0]              level;
	logic [LVL_BITS-1:0]              room;
	logic                             accept;
	push_ctl_t                        push;
	row_tag_t                         head_tag;

	assign pix[0] = pixel_0;
	assign pix[1] = pixel_1;
	assign pix[2] = pixel_2;
	assign pix[3] = pixel_3;
	assign pix[4] = pixel_4;
	assign pix[5] = pixel_5;
	assign pix[6] = pixel_6;
	assign pix[7] = pixel_7;

	// Horizontal pass: edge columns times four, inner columns 1-2-1
	assign hf[0]       = {pix[0], 2'b00};
	assign hf[NCOLS-1] = {pix[NCOLS-1], 2'b00};
	for (genvar c = 1; c < NCOLS - 1; c++) begin : g_hf
		assign hf[c] = HW'(pix[c-1]) + {1'b0, pix[c], 1'b0} + HW'(pix[c+1]);
	end

	// Vertical pass: edge rows round by four, inner rows round by sixteen
	for (genvar c = 0; c < NCOLS; c++) begin : g_vf
		logic [HW:0]   e_new;
		logic [HW:0]   e_cur;
		logic [SW-1:0] s_in;
		assign e_new = {1'b0, hfilt_newer_q[c]} + (HW+1)'(RND_EDGE);
		assign e_cur = {1'b0, hf[c]} + (HW+1)'(RND_EDGE);
		assign s_in  = SW'(hfilt_older_q[c]) + {1'b0, hfilt_newer_q[c], 1'b0}
		             + SW'(hf[c]) + SW'(RND_INNER);
		assign edge_newer[c] = e_new[HW-1:2];
		assign edge_cur[c]   = e_cur[HW-1:2];
		assign inner_row[c]  = s_in[SW-1:4];
	end

	// Results caused by the row at hand: none for the first row, two for the last, one otherwise
	always_comb begin
		if (row_count_q == FIRST_ROW) begin
			need = LVL_BITS'(0);
		end else if (row_count_q == LAST_ROW) begin
			need = LVL_BITS'(2);
		end else begin
			need = LVL_BITS'(1);
		end
	end

	assign room     = LVL_BITS'(QDEPTH) - level;
	assign in_ready = (room >= need);
	assign accept   = in_valid & in_ready;

	// Row 1 emits the top edge row from the stored row; later rows the inner row
	assign push_pix0      = (row_count_q == ROW_BITS'(1)) ? edge_newer : inner_row;
	assign push.count     = accept ? need : '0;
	assign push.tag0.row  = row_count_q - ROW_BITS'(1);
	assign push.tag0.last = (row_count_q != LAST_ROW);
	assign push.tag1.row  = LAST_ROW;
	assign push.tag1.last = 1'b1;

	blf_out_queue #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_pix0 (push_pix0),
		.push_pix1 (edge_cur),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head_tag  (head_tag),
		.head_pix  (head_pix),
		.level     (level)
	);

	assign out_row     = head_tag.row;
	assign run_last    = head_tag.last;
	assign out_pixel_0 = head_pix[0];
	assign out_pixel_1 = head_pix[1];
	assign out_pixel_2 = head_pix[2];
	assign out_pixel_3 = head_pix[3];
	assign out_pixel_4 = head_pix[4];
	assign out_pixel_5 = head_pix[5];
	assign out_pixel_6 = head_pix[6];
	assign out_pixel_7 = head_pix[7];

	// Advance the row counter on every transfer; it wraps into the next block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
		end else if (accept) begin
			row_count_q <= row_count_q + ROW_BITS'(1);
		end
	end

	// Shift the horizontal row history; always written before it is read
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < NCOLS; c++) begin
				hfilt_older_q[c] <= hfilt_newer_q[c];
				hfilt_newer_q[c] <= hf[c];
			end
		end
	end

	// Row counter moves only on an input transfer
	`ASSERT_PROP(a_row_hold, clk, arst_n, !accept |=> $stable(row_count_q), "row counter moved without a transfer")
	// The last row of a block leaves at least its two results queued
	`ASSERT_PROP(a_last_two, clk, arst_n, (accept && row_count_q == LAST_ROW) |=> (level >= LVL_BITS'(2)), "last row did not queue two results")
	// The queue never holds more than its depth
	`ASSERT_NEVER(a_no_over, clk, arst_n, level > LVL_BITS'(QDEPTH), "output queue overfilled")

endmodule
`default_nettype wire

// ----- hdl/blf_out_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blf_out_queue
// Three-entry shifting result queue, up to two writes and one read a cycle.
// ----------------------------------------------------------------------------
module blf_out_queue #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  blf_pkg::push_ctl_t                              push,
	input  logic [blf_pkg::NCOLS-1:0][PIXEL_BITS-1:0]       push_pix0,
	input  logic [blf_pkg::NCOLS-1:0][PIXEL_BITS-1:0]       push_pix1,
	output logic                                            out_valid,
	input  logic                                            out_ready,
	output blf_pkg::row_tag_t                               head_tag,
	output logic [blf_pkg::NCOLS-1:0][PIXEL_BITS-1:0]       head_pix,
	output logic [blf_pkg::LVL_BITS-1:0]                    level
);
	import blf_pkg::*;

	row_tag_t                            tag_q [QDEPTH];
	logic [NCOLS-1:0][PIXEL_BITS-1:0]    pix_q [QDEPTH];
	row_tag_t                            tag_d [QDEPTH];
	logic [NCOLS-1:0][PIXEL_BITS-1:0]    pix_d [QDEPTH];
	logic [LVL_BITS-1:0]                 level_q;
	logic [LVL_BITS-1:0]                 level_d;
	logic [LVL_BITS-1:0]                 base;
	logic                                pop;

	assign out_valid = (level_q != '0);
	assign pop       = out_valid & out_ready;
	assign head_tag  = tag_q[0];
	assign head_pix  = pix_q[0];
	assign level     = level_q;

	always_comb begin
		base = level_q - LVL_BITS'(pop);
		// advance toward the head on a read
		for (int i = 0; i < QDEPTH - 1; i++) begin
			tag_d[i] = pop ? tag_q[i+1] : tag_q[i];
			pix_d[i] = pop ? pix_q[i+1] : pix_q[i];
		end
		tag_d[QDEPTH-1] = tag_q[QDEPTH-1];
		pix_d[QDEPTH-1] = pix_q[QDEPTH-1];
		// append new results behind the survivors
		for (int i = 0; i < QDEPTH; i++) begin
			if (push.count != '0 && base == LVL_BITS'(i)) begin
				tag_d[i] = push.tag0;
				pix_d[i] = push_pix0;
			end
			if (push.count == LVL_BITS'(2) && (base + LVL_BITS'(1)) == LVL_BITS'(i)) begin
				tag_d[i] = push.tag1;
				pix_d[i] = push_pix1;
			end
		end
		level_d = base + push.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else begin
			level_q <= level_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			tag_q[i] <= tag_d[i];
			pix_q[i] <= pix_d[i];
		end
	end

endmodule
`default_nettype wire
